/* hdl/btp_pkg.sv */
package btp_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int FREE_BITS  = NODE_BITS + 1;
    localparam int VALUE_BITS = 32;
    localparam int KEY_BITS   = 128;
    localparam int LEN_BITS   = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef logic [NODE_BITS-1:0] node_idx_t;

    typedef struct packed {
        node_idx_t             link0;
        node_idx_t             link1;
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
    } node_t;

    typedef struct packed {
        logic      rd_en;
        node_idx_t rd_addr;
        logic      wr_en;
        node_idx_t wr_addr;
        node_t     wr_data;
    } ram_req_t;

    typedef struct packed {
        logic        command;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  prefix_length;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

/* hdl/binary_trie_prefix_table_top.sv */
// binary trie prefix table: insert and exact search on 128-bit prefixes
// command channel: a transfer happens on a clock edge with start high and
//   busy low; request carries command, key halves, prefix length and value
// result channel: done is high for exactly one cycle with result valid;
//   the receiver takes the transfer in that cycle and cannot hold it off
// walk: a search or insert descends up to n levels (n = saturated prefix
//   length) in the walk state, and done and result are registered from
//   its finish; a zero-length insert answers in the cycle after its transfer
// commands: one in flight; a new one is taken while the previous result
//   is still on the result ports
// the walk is paced by the node memory: one read or one write per trie level
// reset clears the walker and the free-node counter (next node 1); the root
//   reads as empty until first written, other nodes are written on
//   allocation, so no clearing pass runs over the node memory
module binary_trie_prefix_table_top
    import btp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    ram_req_t ram_req;
    node_t    rdata;
    logic     finish;
    result_t  walk_result;
    logic     done_reg;
    result_t  result_reg;

    // node memory, one synchronous read and one write port
    btp_node_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    // trie walker: one level per cycle, allocation from the bump counter
    btp_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .rdata   (rdata),
        .ram_req (ram_req),
        .busy    (busy),
        .finish  (finish),
        .result  (walk_result)
    );

    // output register, the strobe lasts one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg <= walk_result;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/btp_node_ram.sv */
module btp_node_ram
    import btp_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output node_t    rdata
);

    node_t mem [NODE_COUNT];

    // synchronous write and registered read, one port each
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.rd_addr];
        end
    end

endmodule

/* hdl/btp_walk.sv */
module btp_walk
    import btp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    input  node_t    rdata,
    output ram_req_t ram_req,
    output logic     busy,
    output logic     finish,
    output result_t  result
);

    state_t                state_reg, state_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [LEN_BITS-1:0]   idx_reg, idx_next;
    node_idx_t             node_reg, node_next;
    logic                  fresh_reg, fresh_next;
    logic                  cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [FREE_BITS-1:0]  free_reg, free_next;
    logic                  root_written_reg, root_written_next;

    node_t               cur;
    node_t               linked;
    node_idx_t           child;
    logic                bit_b;
    logic                at_end;
    logic                has_child;
    logic                pool_full;
    logic                accept;
    logic                zero_insert;
    logic [LEN_BITS-1:0] len_sat;

    // a fresh node is known to be all zero and is not read back
    assign cur       = fresh_reg ? node_t'('0) : rdata;
    assign bit_b     = key_reg[KEY_BITS-1];
    assign child     = bit_b ? cur.link1 : cur.link0;
    assign has_child = (child != '0);
    assign at_end    = (idx_reg == len_reg);
    assign pool_full = (free_reg >= FREE_BITS'(NODE_COUNT));
    assign accept    = start && (state_reg == ST_IDLE);
    assign len_sat   = (request.prefix_length > LEN_BITS'(KEY_BITS)) ?
                       LEN_BITS'(KEY_BITS) : request.prefix_length;
    assign zero_insert = (request.command == CMD_INSERT) && (len_sat == '0);
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        linked = cur;
        if (bit_b)
        begin
            linked.link1 = free_reg[NODE_BITS-1:0];
        end
        else
        begin
            linked.link0 = free_reg[NODE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !zero_insert)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (at_end || (!has_child && (cmd_reg == CMD_SEARCH || pool_full)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_next          = key_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        node_next         = node_reg;
        fresh_next        = fresh_reg;
        cmd_next          = cmd_reg;
        value_next        = value_reg;
        free_next         = free_reg;
        root_written_next = root_written_reg;
        ram_req           = '0;
        finish            = 1'b0;
        result            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = {request.key_high, request.key_low};
                    len_next   = len_sat;
                    cmd_next   = request.command;
                    value_next = request.value;
                    idx_next   = '0;
                    node_next  = '0;
                    fresh_next = !root_written_reg;
                    if (zero_insert)
                    begin
                        finish        = 1'b1;
                        result.status = STATUS_ZERO_LEN;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                    end
                end
            end
            ST_WALK:
            begin
                if (at_end)
                begin
                    finish = 1'b1;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        ram_req.wr_en         = 1'b1;
                        ram_req.wr_addr       = node_reg;
                        ram_req.wr_data       = cur;
                        ram_req.wr_data.valid = 1'b1;
                        ram_req.wr_data.value = value_reg;
                        if (node_reg == '0)
                        begin
                            root_written_next = 1'b1;
                        end
                    end
                    else
                    begin
                        result.found     = cur.valid;
                        result.value_out = cur.valid ? cur.value : '0;
                    end
                end
                else if (has_child)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = child;
                    node_next       = child;
                    fresh_next      = 1'b0;
                    idx_next        = idx_reg + 1'b1;
                    key_next        = {key_reg[KEY_BITS-2:0], 1'b0};
                end
                else if (cmd_reg == CMD_SEARCH)
                begin
                    finish = 1'b1;
                end
                else if (pool_full)
                begin
                    // a node linked but not yet written is cleared here
                    finish        = 1'b1;
                    result.status = STATUS_FULL;
                    if (fresh_reg)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = node_reg;
                        ram_req.wr_data = '0;
                        if (node_reg == '0)
                        begin
                            root_written_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // link a new node; it is written when the walk leaves it
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = node_reg;
                    ram_req.wr_data = linked;
                    node_next       = free_reg[NODE_BITS-1:0];
                    fresh_next      = 1'b1;
                    free_next       = free_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    key_next        = {key_reg[KEY_BITS-2:0], 1'b0};
                    if (node_reg == '0)
                    begin
                        root_written_next = 1'b1;
                    end
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            free_reg         <= FREE_BITS'(1);
            root_written_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_reg         <= free_next;
            root_written_reg <= root_written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        node_reg  <= node_next;
        fresh_reg <= fresh_next;
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
    end

endmodule
